// ===== hw/rtl/nbrp_pkg.sv =====
`timescale 1ns / 1ps
// nbrp_pkg: shared types, codes and the alias character check for the
// routing broadcast parser; no dependencies

package nbrp_pkg;

	localparam int ADDRESS_BYTES = 7;
	localparam int ADDR_W        = 8 * ADDRESS_BYTES;
	localparam int ALIAS_OUT_W   = 48;
	localparam int QUAL_W        = 8;
	localparam int CFG_INDEX_W   = 2;

	// byte values used while parsing
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// address compare masks: ssid byte checks bits 1 to 4 only
	localparam logic [7:0] MASK_ADDR_BYTE = 8'hFE;
	localparam logic [7:0] MASK_SSID_BYTE = 8'h1E;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_VIA_ME    = 2'd1,
		ST_LOW_QUAL  = 2'd2,
		ST_BAD_ALIAS = 2'd3
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COMPLIANT_MODE = 2'd0,
		CFG_WORST_QUALITY  = 2'd1,
		CFG_OWN_CALLSIGN   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic              compliant_mode;
		logic [QUAL_W-1:0] worst_quality;
		logic [ADDR_W-1:0] own_callsign;
	} cfg_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic              first_byte;
		logic              last_byte;
		logic [ADDR_W-1:0] neighbour_address;
		logic [QUAL_W-1:0] neighbour_quality;
	} item_t;

	typedef struct packed {
		status_t                status;
		logic                   is_neighbour_entry;
		logic [ADDR_W-1:0]      dest_address;
		logic [ALIAS_OUT_W-1:0] alias_text;
		logic [QUAL_W-1:0]      route_quality;
	} result_t;

	// # _ & - / digits uppercase, lowercase only outside compliant mode
	function automatic logic char_allowed(input logic [7:0] c, input logic compliant);
		logic ok;
		ok = 1'b0;
		if (c == "#" || c == "_" || c == "&" || c == "-" || c == "/")
			ok = 1'b1;
		if (c >= "0" && c <= "9")
			ok = 1'b1;
		if (c >= "A" && c <= "Z")
			ok = 1'b1;
		if (!compliant && c >= "a" && c <= "z")
			ok = 1'b1;
		return ok;
	endfunction

endpackage

// ===== hw/rtl/nbrp_parser.sv =====
`timescale 1ns / 1ps
// nbrp_parser: per-byte parse state and result forming for one staged byte
// depends on nbrp_pkg

module nbrp_parser import nbrp_pkg::*; #(
	parameter int ALIAS_BYTES  = 6,
	parameter int RECORD_BYTES = 21
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	localparam int AL_W    = 8 * ALIAS_BYTES;
	localparam int OUT_W   = (AL_W < ALIAS_OUT_W) ? AL_W : ALIAS_OUT_W;
	localparam int POS_W   = $clog2(RECORD_BYTES);
	localparam int VIA_AT  = ADDRESS_BYTES + ALIAS_BYTES;
	localparam int QUAL_AT = VIA_AT + ADDRESS_BYTES;

	logic                active_q, active_n;
	logic                in_rec_q, in_rec_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic [ADDR_W-1:0]   dest_q, dest_n;
	logic [AL_W-1:0]     alias_q, alias_n;
	logic                ended_q, ended_n;
	logic                good_q, good_n;
	logic                via_me_q, via_me_n;
	logic [ADDR_W-1:0]   held_nb_q, held_nb_n;
	logic [QUAL_W-1:0]   held_q_q, held_q_n;
	logic [QUAL_W-1:0]   rec_q_q, rec_q_n;

	always_comb begin
		int          pos_i;
		logic        take_alias;
		logic [2:0]  k;
		logic [7:0]  own_b;
		logic [7:0]  m;
		logic [15:0] prod;

		active_n  = active_q;
		in_rec_n  = in_rec_q;
		pos_n     = pos_q;
		dest_n    = dest_q;
		alias_n   = alias_q;
		ended_n   = ended_q;
		good_n    = good_q;
		via_me_n  = via_me_q;
		held_nb_n = held_nb_q;
		held_q_n  = held_q_q;
		rec_q_n   = rec_q_q;
		res_valid = 1'b0;
		res       = '0;
		pos_i     = 0;
		take_alias = 1'b0;
		k         = '0;
		own_b     = '0;
		m         = '0;
		prod      = '0;

		if (en) begin
			if (item.first_byte) begin
				active_n  = 1'b1;
				in_rec_n  = 1'b0;
				held_nb_n = item.neighbour_address;
				held_q_n  = item.neighbour_quality;
				pos_n     = '0;
				dest_n    = '0;
				alias_n   = '0;
				ended_n   = 1'b0;
				good_n    = 1'b1;
				via_me_n  = 1'b1;
				rec_q_n   = '0;
			end

			if (active_n) begin
				pos_i = int'(pos_n);
				take_alias = !in_rec_n ||
					(pos_i >= ADDRESS_BYTES && pos_i < VIA_AT);

				if (in_rec_n && pos_i < ADDRESS_BYTES)
					dest_n = ADDR_W'({dest_n, item.data_byte});

				if (take_alias) begin
					if (item.data_byte == CHAR_SPACE || item.data_byte == CHAR_NUL)
						ended_n = 1'b1;
					if (!ended_n && !char_allowed(item.data_byte, cfg.compliant_mode))
						good_n = 1'b0;
					alias_n = AL_W'({alias_n, (ended_n ? 8'h00 : item.data_byte)});
				end

				if (in_rec_n && pos_i >= VIA_AT && pos_i < QUAL_AT) begin
					k     = 3'(pos_i - VIA_AT);
					own_b = cfg.own_callsign[8*(ADDRESS_BYTES-1-int'(k)) +: 8];
					m     = (int'(k) == ADDRESS_BYTES-1) ? MASK_SSID_BYTE : MASK_ADDR_BYTE;
					if ((own_b & m) != (item.data_byte & m))
						via_me_n = 1'b0;
				end

				if (in_rec_n && pos_i == QUAL_AT)
					rec_q_n = item.data_byte;

				if (!in_rec_n) begin
					if (pos_i + 1 >= ALIAS_BYTES) begin
						res_valid              = 1'b1;
						res.status             = good_n ? ST_ACCEPTED : ST_BAD_ALIAS;
						res.is_neighbour_entry = 1'b1;
						res.dest_address       = held_nb_n;
						res.alias_text         = ALIAS_OUT_W'(alias_n[OUT_W-1:0]);
						res.route_quality      = held_q_n;
						in_rec_n = 1'b1;
						pos_n    = '0;
						dest_n   = '0;
						alias_n  = '0;
						ended_n  = 1'b0;
						good_n   = 1'b1;
						via_me_n = 1'b1;
						rec_q_n  = '0;
					end else begin
						pos_n = POS_W'(pos_i + 1);
					end
				end else begin
					if (pos_i + 1 >= RECORD_BYTES) begin
						prod = 16'(held_q_n) * 16'(rec_q_n) + 16'd128;
						res_valid = 1'b1;
						if (via_me_n)
							res.status = ST_VIA_ME;
						else if (rec_q_n <= cfg.worst_quality)
							res.status = ST_LOW_QUAL;
						else if (!good_n)
							res.status = ST_BAD_ALIAS;
						else
							res.status = ST_ACCEPTED;
						res.is_neighbour_entry = 1'b0;
						res.dest_address       = dest_n;
						res.alias_text         = ALIAS_OUT_W'(alias_n[OUT_W-1:0]);
						res.route_quality      = prod[15:8];
						pos_n    = '0;
						dest_n   = '0;
						alias_n  = '0;
						ended_n  = 1'b0;
						good_n   = 1'b1;
						via_me_n = 1'b1;
						rec_q_n  = '0;
					end else begin
						pos_n = POS_W'(pos_i + 1);
					end
				end
			end

			if (item.last_byte) begin
				active_n = 1'b0;
				in_rec_n = 1'b0;
				pos_n    = '0;
				dest_n   = '0;
				alias_n  = '0;
				ended_n  = 1'b0;
				good_n   = 1'b1;
				via_me_n = 1'b1;
				rec_q_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			in_rec_q  <= 1'b0;
			pos_q     <= '0;
			dest_q    <= '0;
			alias_q   <= '0;
			ended_q   <= 1'b0;
			good_q    <= 1'b1;
			via_me_q  <= 1'b1;
			held_nb_q <= '0;
			held_q_q  <= '0;
			rec_q_q   <= '0;
		end else begin
			active_q  <= active_n;
			in_rec_q  <= in_rec_n;
			pos_q     <= pos_n;
			dest_q    <= dest_n;
			alias_q   <= alias_n;
			ended_q   <= ended_n;
			good_q    <= good_n;
			via_me_q  <= via_me_n;
			held_nb_q <= held_nb_n;
			held_q_q  <= held_q_n;
			rec_q_q   <= rec_q_n;
		end
	end

endmodule

// ===== hw/rtl/nodes_broadcast_route_parser.sv =====
`timescale 1ns / 1ps
// nodes_broadcast_route_parser: top level of the routing broadcast parser
// depends on nbrp_pkg and nbrp_parser
//
// usage
//   input channel (in_valid / in_stall) carries one payload byte per transfer,
//   with first_byte / last_byte packet marks and the neighbour address and
//   link quality, which are sampled on the first byte of a packet
//   output channel (out_valid / out_stall) carries one route entry: the
//   neighbour entry after the alias header, then one entry per full record
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   compliant_mode, worst_quality and own_callsign; cfg_ready is always high
// pipeline and throughput
//   a byte transfer is captured in the input register, parsed by the parse
//   stage, and any entry it closes passes the result register to the output
//   one byte per cycle sustained while no entry waits under out_stall; the
//   single 8x8 quality scaling multiply and the via-address compare sit
//   between the input and result registers
// reset
//   arst_n clears config to zero, drops any packet in progress and empties
//   both pipeline registers
// stall
//   while an entry waits under out_stall the parse stage holds; an empty
//   input register still takes one more byte, then in_stall rises

module nodes_broadcast_route_parser import nbrp_pkg::*; #(
	parameter int ALIAS_BYTES  = 6,
	parameter int RECORD_BYTES = 21
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// byte channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   first_byte,
	input  logic                   last_byte,
	input  logic [ADDR_W-1:0]      neighbour_address,
	input  logic [QUAL_W-1:0]      neighbour_quality,
	// route entry channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic                   is_neighbour_entry,
	output logic [ADDR_W-1:0]      dest_address,
	output logic [ALIAS_OUT_W-1:0] alias_text,
	output logic [QUAL_W-1:0]      route_quality,
	// config write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;

	logic    advance;
	logic    in_xfer;
	logic    parse_en;
	logic    res_valid;
	result_t res;

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_COMPLIANT_MODE: cfg_q.compliant_mode <= cfg_data[0];
				CFG_WORST_QUALITY:  cfg_q.worst_quality  <= cfg_data[QUAL_W-1:0];
				CFG_OWN_CALLSIGN:   cfg_q.own_callsign   <= cfg_data;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// pipeline moves unless a finished entry is held by the receiver
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;
	assign parse_en = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.data_byte         <= data_byte;
			item_s1.first_byte        <= first_byte;
			item_s1.last_byte         <= last_byte;
			item_s1.neighbour_address <= neighbour_address;
			item_s1.neighbour_quality <= neighbour_quality;
		end
	end

	// parse stage: state update and entry forming
	nbrp_parser #(
		.ALIAS_BYTES  (ALIAS_BYTES),
		.RECORD_BYTES (RECORD_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (parse_en),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= parse_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && parse_en && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid          = valid_s2;
	assign status             = res_s2.status;
	assign is_neighbour_entry = res_s2.is_neighbour_entry;
	assign dest_address       = res_s2.dest_address;
	assign alias_text         = res_s2.alias_text;
	assign route_quality      = res_s2.route_quality;

endmodule
